// ===== hdl/ohrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ohrb_pkg
// Shared types for the overwriting history ring buffer: request and response
// beats, record layout, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ohrb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } ohrb_op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        ms_stamp;
    logic [31:0]        doppler_bits;
    logic [31:0]        phase_bits;
    logic signed [31:0] code_phase;
    logic [31:0]        in_phase_bits;
    logic [31:0]        quadrature_bits;
    logic [31:0]        snr_bits;
    logic [31:0]        lock_bits;
    logic [5:0]         peek_offset;
  } ohrb_req_t;

  typedef struct packed {
    logic               status;
    logic [31:0]        out_ms_stamp;
    logic [31:0]        out_doppler_bits;
    logic [31:0]        out_phase_bits;
    logic signed [31:0] out_code_phase;
    logic [31:0]        out_in_phase_bits;
    logic [31:0]        out_quadrature_bits;
    logic [31:0]        out_snr_bits;
    logic [31:0]        out_lock_bits;
    logic [5:0]         entry_count;
  } ohrb_rsp_t;

  // One stored record, as kept in the history RAM.
  typedef struct packed {
    logic [31:0]        ms_stamp;
    logic [31:0]        doppler_bits;
    logic [31:0]        phase_bits;
    logic signed [31:0] code_phase;
    logic [31:0]        in_phase_bits;
    logic [31:0]        quadrature_bits;
  } ohrb_rec_t;

  localparam int REC_W   = $bits(ohrb_rec_t);
  localparam int COUNT_W = 6;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DONE = 1'b1
  } ohrb_state_t;

  typedef struct packed {
    logic start;  // take the request beat and run its operation
    logic load;   // move the finished result into the response register
  } ohrb_cmd_t;

  typedef struct packed {
    logic rsp_free;  // response register is empty or drains this cycle
  } ohrb_stat_t;

endpackage

// ===== hdl/ohrb_ram.sv =====
// ----------------------------------------------------------------------------
// ohrb_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds when no read is issued.
// ----------------------------------------------------------------------------
module ohrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ohrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohrb_ctrl
// Controller: takes a request beat when idle, then waits for room in the
// response register before loading the result.
// ----------------------------------------------------------------------------
module ohrb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  ohrb_pkg::ohrb_stat_t stat,
  output ohrb_pkg::ohrb_cmd_t  cmd
);
  import ohrb_pkg::*;

  ohrb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.rsp_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/ohrb_dp.sv =====
// ----------------------------------------------------------------------------
// ohrb_dp
// Datapath: ring pointers, latched SNR/lock words, record RAM, pending
// result flags and the response register.
// ----------------------------------------------------------------------------
module ohrb_dp #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  ohrb_pkg::ohrb_req_t  req,
  input  ohrb_pkg::ohrb_cmd_t  cmd,
  output ohrb_pkg::ohrb_stat_t stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output ohrb_pkg::ohrb_rsp_t  rsp
);
  import ohrb_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_E = (IDX_W + 1)'(DEPTH);
  localparam logic [CW:0]      DEPTH_S = (CW + 1)'(DEPTH);

  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [31:0]      snr_latch, lock_latch;
  logic             pend_ok, pend_show;

  logic [IDX_W-1:0] wr_inc, rd_inc, count, slot, raddr;
  logic [IDX_W:0]   wrap_sum;
  logic [CW:0]      slot_sum;
  logic [CW-1:0]    count_ext, offset_ext;
  logic             we, ok, show;
  ohrb_rec_t        wrec, rrec;

  function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] x);
    bump = (x == LAST) ? '0 : x + 1'b1;
  endfunction

  assign wr_inc = bump(wr_idx);
  assign rd_inc = bump(rd_idx);

  // Held entries; the wrapped form is below DEPTH so it fits the index width.
  assign wrap_sum = {1'b0, wr_idx} + DEPTH_E - {1'b0, rd_idx};
  assign count    = (wr_idx >= rd_idx) ? (wr_idx - rd_idx) : wrap_sum[IDX_W-1:0];

  assign count_ext  = CW'(count);
  assign offset_ext = CW'(req.peek_offset);

  // Peek slot: offset is below count when used, so one subtract wraps it.
  always_comb begin
    slot_sum = (CW + 1)'(rd_idx) + (CW + 1)'(req.peek_offset);
    if (slot_sum >= DEPTH_S) begin
      slot_sum = slot_sum - DEPTH_S;
    end
    slot = slot_sum[IDX_W-1:0];
  end

  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    we          = 1'b0;
    ok          = 1'b0;
    show        = 1'b0;
    raddr       = rd_idx;
    case (ohrb_op_t'(req.op))
      OP_PUSH: begin
        we          = 1'b1;
        ok          = 1'b1;
        wr_idx_next = wr_inc;
        if (wr_inc == rd_idx) begin
          rd_idx_next = rd_inc;
        end
      end
      OP_POP: begin
        if (count != '0) begin
          ok          = 1'b1;
          show        = 1'b1;
          rd_idx_next = rd_inc;
        end
      end
      OP_PEEK: begin
        raddr = slot;
        if (offset_ext < count_ext) begin
          ok   = 1'b1;
          show = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wrec.ms_stamp        = req.ms_stamp;
  assign wrec.doppler_bits    = req.doppler_bits;
  assign wrec.phase_bits      = req.phase_bits;
  assign wrec.code_phase      = req.code_phase;
  assign wrec.in_phase_bits   = req.in_phase_bits;
  assign wrec.quadrature_bits = req.quadrature_bits;

  ohrb_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.start & we),
    .waddr(wr_idx),
    .wdata(wrec),
    .re   (cmd.start),
    .raddr(raddr),
    .rdata(rrec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx     <= '0;
      rd_idx     <= '0;
      snr_latch  <= '0;
      lock_latch <= '0;
    end else if (cmd.start) begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      if (ohrb_op_t'(req.op) == OP_PUSH) begin
        snr_latch  <= req.snr_bits;
        lock_latch <= req.lock_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pend_ok   <= ok;
      pend_show <= show;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Pointers already hold their new values here, so count is post-operation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rsp.status              <= ~pend_ok;
      rsp.out_ms_stamp        <= pend_show ? rrec.ms_stamp        : '0;
      rsp.out_doppler_bits    <= pend_show ? rrec.doppler_bits    : '0;
      rsp.out_phase_bits      <= pend_show ? rrec.phase_bits      : '0;
      rsp.out_code_phase      <= pend_show ? rrec.code_phase      : '0;
      rsp.out_in_phase_bits   <= pend_show ? rrec.in_phase_bits   : '0;
      rsp.out_quadrature_bits <= pend_show ? rrec.quadrature_bits : '0;
      rsp.out_snr_bits        <= snr_latch;
      rsp.out_lock_bits       <= lock_latch;
      rsp.entry_count         <= count_ext[COUNT_W-1:0];
    end
  end

  assign stat.rsp_free = ~rsp_valid | rsp_ready;

endmodule

// ===== hdl/overwriting_history_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// overwriting_history_ring_buffer
// Ring of tracking records that drops the oldest record when full.
// ----------------------------------------------------------------------------
// Order: a request beat is taken in ST_IDLE; its response is registered from
//   ST_DONE once the response register is free.
// Flow: the controller takes a beat, then loads its response once the
//   registered RAM read lands; it takes no new beat before then. A response
//   held by the receiver keeps the controller waiting and the request port stalled.
// Reset: pointers and the SNR/lock words clear to zero; the record RAM is
//   not cleared and needs no clearing pass, since only written entries reach a response.
module overwriting_history_ring_buffer #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ohrb_pkg::ohrb_req_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ohrb_pkg::ohrb_rsp_t rsp
);
  import ohrb_pkg::*;

  ohrb_cmd_t  cmd;
  ohrb_stat_t stat;

  // Controller: accept one beat, then hold until the response register frees.
  ohrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: advance pointers and write or read the RAM on start, load the
  // response on load.
  ohrb_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

// ===== tb/overwriting_history_ring_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting_history_ring_buffer_tb
// Self-checking bench for the tracking-record history ring. A scoreboard
// keeps its own copy of the ring, the pointers and the SNR/lock latches and
// works out the response for every request beat the block takes. A driver
// and a monitor, both clocked, move request and response beats with random
// idle bursts. Stimulus is a directed opening, then random phases that fill,
// overwrite, peek into and drain the ring. One long response back-pressure
// stretch stalls the block and makes it hold off its request port.
// ----------------------------------------------------------------------------
module overwriting_history_ring_buffer_tb;
  import ohrb_pkg::*;

  localparam int RING_DEPTH  = 64;
  localparam int ITEM_TARGET = 800;
  localparam int TAIL_BEATS  = 100;     // last beats run without idling
  localparam int HOLD_AFTER  = 300;     // request beats before the long hold-off
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_WAIT  = 12;      // margin after the last response
  localparam int CYCLE_LIMIT = 200000;  // watchdog bound on the whole run

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  ohrb_req_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  ohrb_rsp_t rsp;

  overwriting_history_ring_buffer #(
    .DEPTH(RING_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #4 clk = ~clk;

  // Request beats waiting to be driven, and responses owed by the block.
  ohrb_req_t queued_requests[$];
  ohrb_rsp_t due_responses[$];

  // Scoreboard copy of the ring.
  ohrb_rec_t   history [RING_DEPTH];
  int          wr_ptr = 0;
  int          rd_ptr = 0;
  logic [31:0] snr_latched  = '0;
  logic [31:0] lock_latched = '0;

  // Run bookkeeping.
  int errors      = 0;
  int cycles      = 0;
  int total_beats = 0;
  int beats_sent  = 0;
  int beats_seen  = 0;
  int gen_held    = 0;
  int n_pushes    = 0;
  int n_dropped   = 0;
  int n_pops      = 0;
  int n_peeks     = 0;
  int n_rejects   = 0;
  int peak_held   = 0;

  // Idle control for both sides.
  int send_gap      = 0;
  int recv_gap      = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // Copy a stored record into the record fields of a response.
  function automatic ohrb_rsp_t with_record(input ohrb_rsp_t o, input ohrb_rec_t rec);
    ohrb_rsp_t t;
    t = o;
    t.out_ms_stamp        = rec.ms_stamp;
    t.out_doppler_bits    = rec.doppler_bits;
    t.out_phase_bits      = rec.phase_bits;
    t.out_code_phase      = rec.code_phase;
    t.out_in_phase_bits   = rec.in_phase_bits;
    t.out_quadrature_bits = rec.quadrature_bits;
    return t;
  endfunction

  // Apply one request to the scoreboard ring and return the response it owes.
  function automatic ohrb_rsp_t ring_response(input ohrb_req_t r);
    ohrb_rsp_t o;
    int        held;
    int        slot;
    o        = '0;
    o.status = 1'b1;
    held     = (wr_ptr - rd_ptr + RING_DEPTH) % RING_DEPTH;
    case (ohrb_op_t'(r.op))
      OP_PUSH: begin
        history[wr_ptr].ms_stamp        = r.ms_stamp;
        history[wr_ptr].doppler_bits    = r.doppler_bits;
        history[wr_ptr].phase_bits      = r.phase_bits;
        history[wr_ptr].code_phase      = r.code_phase;
        history[wr_ptr].in_phase_bits   = r.in_phase_bits;
        history[wr_ptr].quadrature_bits = r.quadrature_bits;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        // Write pointer caught the read pointer: drop the oldest record.
        if (wr_ptr == rd_ptr) begin
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          n_dropped++;
        end
        snr_latched  = r.snr_bits;
        lock_latched = r.lock_bits;
        o.status     = 1'b0;
        n_pushes++;
      end
      OP_POP: begin
        if (held > 0) begin
          o      = with_record(o, history[rd_ptr]);
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          o.status = 1'b0;
          n_pops++;
        end
      end
      OP_PEEK: begin
        if (int'(r.peek_offset) < held) begin
          slot     = (rd_ptr + int'(r.peek_offset)) % RING_DEPTH;
          o        = with_record(o, history[slot]);
          o.status = 1'b0;
          n_peeks++;
        end
      end
      default: ;
    endcase
    if (o.status) n_rejects++;
    held = (wr_ptr - rd_ptr + RING_DEPTH) % RING_DEPTH;
    if (held > peak_held) peak_held = held;
    o.out_snr_bits  = snr_latched;
    o.out_lock_bits = lock_latched;
    o.entry_count   = held[5:0];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic compare_response(input ohrb_rsp_t want, input ohrb_rsp_t got);
    check_field("status",              32'(want.status),         32'(got.status));
    check_field("out_ms_stamp",        want.out_ms_stamp,        got.out_ms_stamp);
    check_field("out_doppler_bits",    want.out_doppler_bits,    got.out_doppler_bits);
    check_field("out_phase_bits",      want.out_phase_bits,      got.out_phase_bits);
    check_field("out_code_phase",      want.out_code_phase,      got.out_code_phase);
    check_field("out_in_phase_bits",   want.out_in_phase_bits,   got.out_in_phase_bits);
    check_field("out_quadrature_bits", want.out_quadrature_bits, got.out_quadrature_bits);
    check_field("out_snr_bits",        want.out_snr_bits,        got.out_snr_bits);
    check_field("out_lock_bits",       want.out_lock_bits,       got.out_lock_bits);
    check_field("entry_count",         32'(want.entry_count),    32'(got.entry_count));
  endtask

  // Mostly random words, with a fair share of the corner patterns.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic ohrb_req_t build_request(input ohrb_op_t op, input logic [5:0] offset);
    ohrb_req_t r;
    r.op              = op;
    r.ms_stamp        = rand_word();
    r.doppler_bits    = rand_word();
    r.phase_bits      = rand_word();
    r.code_phase      = rand_word();
    r.in_phase_bits   = rand_word();
    r.quadrature_bits = rand_word();
    r.snr_bits        = rand_word();
    r.lock_bits       = rand_word();
    r.peek_offset     = offset;
    return r;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Queue a request and track the fill level it leaves, so peeks can aim
  // inside the held range.
  task automatic enqueue(input ohrb_req_t r);
    queued_requests.push_back(r);
    case (ohrb_op_t'(r.op))
      OP_PUSH: if (gen_held < RING_DEPTH - 1) gen_held++;
      OP_POP:  if (gen_held > 0) gen_held--;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: take the beat at the edge where valid and ready meet, predict its
  // response, then offer the next beat or idle for a burst.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic fire;
    logic tail;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      fire = req_valid && req_ready;
      tail = beats_sent >= total_beats - TAIL_BEATS;
      if (fire) begin
        due_responses.push_back(ring_response(req));
        void'(queued_requests.pop_front());
        beats_sent++;
        if (beats_sent % 64 == 0) send_idle_pct = pick_idle_pct();
      end
      // Hold valid and payload until the beat is taken.
      if (!req_valid || fire) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (queued_requests.size() == 0) begin
          req_valid <= 1'b0;
        end else if (!tail && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap  = $urandom_range(1, 6) - 1;
          req_valid <= 1'b0;
        end else begin
          req_valid <= 1'b1;
          req       <= queued_requests[0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each response beat against the oldest owed one, and drive
  // ready with stall bursts plus one long hold-off that stalls the request port.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ohrb_rsp_t want;
    logic      tail;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      tail = beats_sent >= total_beats - TAIL_BEATS;
      if (rsp_valid && rsp_ready) begin
        if (due_responses.size() == 0) begin
          $display("%0t: response beat with nothing expected, got %h", $time, rsp);
          errors++;
        end else begin
          want = due_responses.pop_front();
          compare_response(want, rsp);
        end
        beats_seen++;
        if (beats_seen % 64 == 0) recv_idle_pct = pick_idle_pct();
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (!hold_done && beats_sent >= HOLD_AFTER) begin
        // Long hold-off: the sender keeps offering, so the block must stall.
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_ready <= 1'b0;
      end else if (!tail && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap  = $urandom_range(1, 6) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d request beats taken, %0d responses owed",
               $time, beats_sent, total_beats, due_responses.size());
      $display("** overwriting_history_ring_buffer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    ohrb_req_t r;
    int        phase;
    int        len;
    int        pick;
    int        off;
    ohrb_op_t  op;

    // Directed opening: empty ring, unknown op, corner words, peek edges.
    enqueue(build_request(OP_POP, 6'd0));          // pop when empty
    enqueue(build_request(OP_PEEK, 6'd0));         // peek into an empty ring
    enqueue(build_request(OP_PEEK, 6'd63));
    enqueue(build_request(OP_NONE, 6'd5));         // unknown op
    r    = '1;                                     // all-ones record and latches
    r.op = OP_PUSH;
    enqueue(r);
    r    = '0;                                     // all-zeros record and latches
    r.op = OP_PUSH;
    enqueue(r);
    r            = build_request(OP_PUSH, 6'd0);
    r.code_phase = 32'sh8000_0000;                 // most negative code phase
    enqueue(r);
    enqueue(build_request(OP_PEEK, 6'd0));
    enqueue(build_request(OP_PEEK, 6'd1));
    enqueue(build_request(OP_PEEK, 6'd2));
    enqueue(build_request(OP_PEEK, 6'd3));         // offset equal to count
    enqueue(build_request(OP_PEEK, 6'd63));
    enqueue(build_request(OP_NONE, 6'd0));         // unknown op, ring not empty
    enqueue(build_request(OP_POP, 6'd0));
    enqueue(build_request(OP_POP, 6'd0));
    enqueue(build_request(OP_POP, 6'd0));
    enqueue(build_request(OP_POP, 6'd0));          // back to empty
    enqueue(build_request(OP_PUSH, 6'd0));
    enqueue(build_request(OP_PEEK, 6'd0));
    enqueue(build_request(OP_POP, 6'd0));
    enqueue(build_request(OP_PUSH, 6'd0));
    enqueue(build_request(OP_PUSH, 6'd0));
    enqueue(build_request(OP_PEEK, 6'd1));

    // Random phases: fill past the wrap, mixed traffic, drain, peek-heavy.
    phase = 0;
    while (queued_requests.size() < ITEM_TARGET) begin
      len = $urandom_range(60, 140);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        case (phase % 4)
          0:       op = pick < 85 ? OP_PUSH : pick < 90 ? OP_POP : pick < 98 ? OP_PEEK : OP_NONE;
          1:       op = pick < 45 ? OP_PUSH : pick < 75 ? OP_POP : pick < 97 ? OP_PEEK : OP_NONE;
          2:       op = pick < 15 ? OP_PUSH : pick < 80 ? OP_POP : pick < 98 ? OP_PEEK : OP_NONE;
          default: op = pick < 25 ? OP_PUSH : pick < 45 ? OP_POP : pick < 98 ? OP_PEEK : OP_NONE;
        endcase
        // Aim most peeks inside the held range; the rest land anywhere.
        if (gen_held > 0 && $urandom_range(0, 3) != 0) off = $urandom_range(0, gen_held - 1);
        else off = $urandom_range(0, 63);
        enqueue(build_request(op, off[5:0]));
      end
      phase++;
    end
    total_beats = queued_requests.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (queued_requests.size() != 0 || due_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d request beats: %0d pushes (%0d dropped the oldest record), "
             , total_beats, n_pushes, n_dropped);
    $display("  %0d pops, %0d peeks, %0d rejected; ring peaked at %0d records; %0d mismatches",
             n_pops, n_peeks, n_rejects, peak_held, errors);
    if (errors == 0) begin
      $display("** overwriting_history_ring_buffer: PASSED **");
    end else begin
      $display("** overwriting_history_ring_buffer: FAILED **");
    end
    $finish;
  end

endmodule
